@@ sv/track_sample_lookup_interp_defines.svh @@
// Assertion macros used by the track sample lookup controller.
// No dependencies.
`ifndef TRACK_SAMPLE_LOOKUP_INTERP_DEFINES_SVH
`define TRACK_SAMPLE_LOOKUP_INTERP_DEFINES_SVH
`define TSL_ASSERT_IMP(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TSL_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ sv/tsl_pkg.sv @@
// Package for the track sample lookup block: types, codes, constants.
// No dependencies.
package tsl_pkg;
	localparam int unsigned STAMP_W = 48;
	localparam int unsigned POS_W = 63;
	localparam int unsigned MOT_W = 64;
	localparam int unsigned FRAC_W = 16;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CRESET = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INTERP   = 3'd0,
		ST_SAMPLE   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_APPENDED = 3'd3,
		ST_REJECTED = 3'd4,
		ST_CRESET   = 3'd5
	} status_t;

	localparam logic [0:0] CFG_MODE = 1'b0;
	localparam logic [0:0] CFG_TOL  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPEND,
		S_QFIRST,
		S_QLAST,
		S_QCHK,
		S_RD,
		S_RDWAIT,
		S_EVAL,
		S_DIV,
		S_LERP,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic        cap_in;       // capture the input item
		logic        do_append;    // write item into the tables
		logic        rd_first;     // read entry 0 stamp
		logic        rd_last;      // read last entry stamp
		logic        ld_first;     // latch first stamp
		logic        ld_last;      // latch last stamp
		logic        init_cur;     // clamp cursor, choose direction
		logic        step_cur;     // move cursor one place
		logic        div_start;
		logic        lerp_go;
		logic        commit;       // update search cursor and previous query
		logic        creset;
		logic        emit;
		status_t     emit_status;
	} tsl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		opcode_t op;
		logic    append_ok;
		logic    out_of_span;
		logic    hit_interp;
		logic    hit_sample;
		logic    walk_end;
		logic    tol_hit;
		logic    div_done;
		logic    lerp_done;
	} tsl_sts_t;
endpackage

@@ sv/track_sample_lookup_interp.sv @@
// Track sample lookup, one item at a time. Append, cursor reset and unknown opcode go from
// the accepting edge through S_APPEND to S_DONE; a query reads the first and last stamps, stops
// there when out of span, else walks the cursor, and when it interpolates divides, then lerps.
// busy drops as done rises, so the next item may start then, and not before the last is done.
// Async active-low reset clears sample count, cursor and previous query and restores the
// config defaults. Results show for one cycle on done; the receiver cannot stall.
module track_sample_lookup_interp #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic [1:0]          opcode,
	input  logic [47:0]         stamp_ms,
	input  logic                grounded,
	input  logic signed [17:0]  altitude_ft,
	input  logic signed [30:0]  lat_e7,
	input  logic signed [31:0]  lon_e7,
	input  logic signed [15:0]  climb_ft_min,
	input  logic [13:0]         speed_eighth_kt,
	input  logic [14:0]         heading_64th_deg,
	output logic                done,
	output logic [2:0]          status,
	output logic [47:0]         out_stamp_ms,
	output logic                out_grounded,
	output logic signed [17:0]  out_altitude_ft,
	output logic signed [30:0]  out_lat_e7,
	output logic signed [31:0]  out_lon_e7,
	output logic signed [15:0]  out_climb_ft_min,
	output logic [13:0]         out_speed_eighth_kt,
	output logic [14:0]         out_heading_64th_deg
);
	import tsl_pkg::*;
	tsl_cmd_t cmd;
	tsl_sts_t sts;
	logic mode_q;
	logic [15:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			tol_q <= 16'd1000;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODE) mode_q <= cfg_wdata[0];
			else tol_q <= cfg_wdata;
		end
	end

	tsl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	tsl_datapath #(.DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_mode(mode_q), .cfg_tol(tol_q),
		.in_opcode(opcode), .in_stamp(stamp_ms), .in_grounded(grounded),
		.in_altitude(altitude_ft), .in_lat(lat_e7), .in_lon(lon_e7),
		.in_climb(climb_ft_min), .in_speed(speed_eighth_kt), .in_heading(heading_64th_deg),
		.done(done), .status(status), .out_stamp_ms(out_stamp_ms),
		.out_grounded(out_grounded), .out_altitude_ft(out_altitude_ft),
		.out_lat_e7(out_lat_e7), .out_lon_e7(out_lon_e7),
		.out_climb_ft_min(out_climb_ft_min), .out_speed_eighth_kt(out_speed_eighth_kt),
		.out_heading_64th_deg(out_heading_64th_deg)
	);
endmodule

@@ sv/tsl_div.sv @@
// Restoring divider, one quotient bit a cycle, for the interpolation fraction.
// Depends on tsl_pkg.
module tsl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsl_pkg::STAMP_W-1:0] num,
	input  logic [tsl_pkg::STAMP_W-1:0] den,
	output logic                        done,
	output logic [tsl_pkg::FRAC_W-1:0]  quo
);
	import tsl_pkg::*;
	localparam int unsigned CNT_W = $clog2(FRAC_W + 1);
	logic [STAMP_W:0] rem_q;
	logic [STAMP_W-1:0] den_q;
	logic [FRAC_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [STAMP_W+1:0] sh;
	logic ge;

	// num < den, so rem stays below den
	assign sh = {rem_q, 1'b0};
	assign ge = sh >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(FRAC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (STAMP_W+1)'(sh - {2'b00, den_q}) : sh[STAMP_W:0];
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done = !busy_q && !start;
	assign quo = quo_q;
endmodule

@@ sv/tsl_datapath.sv @@
// Datapath: sample tables, cursor, compares, divider and per-field lerp.
// Depends on tsl_pkg and tsl_div.
module tsl_datapath #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsl_pkg::tsl_cmd_t           cmd,
	output tsl_pkg::tsl_sts_t           sts,
	input  logic                        cfg_mode,
	input  logic [15:0]                 cfg_tol,
	input  logic [1:0]                  in_opcode,
	input  logic [tsl_pkg::STAMP_W-1:0] in_stamp,
	input  logic                        in_grounded,
	input  logic signed [17:0]          in_altitude,
	input  logic signed [30:0]          in_lat,
	input  logic signed [31:0]          in_lon,
	input  logic signed [15:0]          in_climb,
	input  logic [13:0]                 in_speed,
	input  logic [14:0]                 in_heading,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [tsl_pkg::STAMP_W-1:0] out_stamp_ms,
	output logic                        out_grounded,
	output logic signed [17:0]          out_altitude_ft,
	output logic signed [30:0]          out_lat_e7,
	output logic signed [31:0]          out_lon_e7,
	output logic signed [15:0]          out_climb_ft_min,
	output logic [13:0]                 out_speed_eighth_kt,
	output logic [14:0]                 out_heading_64th_deg
);
	import tsl_pkg::*;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [STAMP_W-1:0] stamp_mem [DEPTH];
	logic [POS_W-1:0]   pos_mem [DEPTH];
	logic [MOT_W-1:0]   mot_mem [DEPTH];

	logic [CW-1:0] count_q;
	logic [AW-1:0] cursor_q, cur_q;
	logic [STAMP_W-1:0] prev_q;
	logic [1:0] op_q;
	logic [STAMP_W-1:0] q_q, first_q, last_q;
	logic [POS_W-1:0] pos_in_q;
	logic [MOT_W-1:0] mot_in_q;
	logic fwd_q;

	// read ports: A at cur (or entry 0 / last entry for the span reads), B at neighbor
	logic [AW-1:0] ra, rb;
	logic [STAMP_W-1:0] ta_q, tb_q;
	logic [POS_W-1:0] pa_q, pb_q;
	logic [MOT_W-1:0] ma_q, mb_q;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] nb;
	logic has_next, at_zero;

	logic div_done;
	logic [FRAC_W-1:0] frac;
	logic lerp_done;

	assign last_idx = AW'(count_q - 1'b1);
	assign has_next = ({1'b0, cur_q} + 1'b1) < (AW+1)'(count_q);
	assign at_zero = cur_q == '0;
	// neighbor is cur-1 on a backward closest walk, else cur+1, held at cur at either end
	assign nb = (!fwd_q && !cfg_mode) ? (at_zero ? cur_q : AW'(cur_q - 1'b1))
	                                  : (has_next ? AW'(cur_q + 1'b1) : cur_q);

	always_comb begin
		ra = cur_q;
		rb = nb;
		if (cmd.rd_first) ra = '0;
		if (cmd.rd_last) ra = last_idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.do_append && sts.append_ok) begin
			stamp_mem[AW'(count_q)] <= q_q;
			pos_mem[AW'(count_q)] <= pos_in_q;
			mot_mem[AW'(count_q)] <= mot_in_q;
		end
		ta_q <= stamp_mem[ra];
		pa_q <= pos_mem[ra];
		ma_q <= mot_mem[ra];
		tb_q <= stamp_mem[rb];
		pb_q <= pos_mem[rb];
		mb_q <= mot_mem[rb];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q <= in_opcode;
			q_q <= in_stamp;
			pos_in_q <= {in_lon, in_lat};
			mot_in_q <= {in_heading, in_speed, in_climb, in_altitude, in_grounded};
		end
		if (cmd.ld_first) first_q <= ta_q;
		if (cmd.ld_last) last_q <= ta_q;
	end

	function automatic logic [STAMP_W-1:0] adiff(input logic [STAMP_W-1:0] a,
		input logic [STAMP_W-1:0] b);
		adiff = (a > b) ? a - b : b - a;
	endfunction

	logic [STAMP_W-1:0] da, db;
	assign da = adiff(ta_q, q_q);
	assign db = adiff(tb_q, q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cursor_q <= '0;
			prev_q <= '0;
			cur_q <= '0;
			fwd_q <= 1'b1;
		end else begin
			if (cmd.do_append && sts.append_ok) count_q <= count_q + 1'b1;
			if (cmd.init_cur) begin
				cur_q <= ({1'b0, cursor_q} >= (AW+1)'(count_q)) ? last_idx : cursor_q;
				fwd_q <= q_q >= prev_q;
			end else if (cmd.step_cur) begin
				cur_q <= fwd_q ? AW'(cur_q + 1'b1) : AW'(cur_q - 1'b1);
			end
			if (cmd.commit) begin
				cursor_q <= cur_q;
				prev_q <= q_q;
			end
			if (cmd.creset) begin
				cursor_q <= '0;
				prev_q <= '0;
			end
		end
	end

	// interp bracket valid only when neighbor is really cur+1
	logic in_br;
	assign in_br = has_next && q_q >= ta_q && q_q < tb_q;

	always_comb begin
		sts.op = opcode_t'(op_q);
		sts.append_ok = (count_q < CW'(DEPTH)) && (count_q == '0 || q_q > ta_q);
		sts.out_of_span = (count_q == '0) || q_q < first_q || q_q > last_q;
		sts.hit_interp = cfg_mode && in_br;
		sts.hit_sample = !cfg_mode && (fwd_q ? (has_next && da < db) : (!at_zero && da < db));
		sts.walk_end = fwd_q ? !has_next : at_zero;
		sts.tol_hit = da < {32'd0, cfg_tol};
		sts.div_done = div_done;
		sts.lerp_done = lerp_done;
	end

	tsl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(STAMP_W'(q_q - ta_q)), .den(STAMP_W'(tb_q - ta_q)),
		.done(div_done), .quo(frac)
	);

	// one field per cycle through a shared multiplier
	logic [2:0] fld_q;
	logic lerp_busy_q;
	logic signed [32:0] fa, fb;
	logic signed [33:0] dlt;
	logic signed [50:0] prod_s1;
	logic [2:0] fld_s1;
	logic v_s1;
	logic signed [32:0] a_s1;
	logic signed [32:0] res [1:6];

	always_comb begin
		fa = '0;
		fb = '0;
		case (fld_q)
			3'd1: begin fa = 33'(signed'(ma_q[18:1])); fb = 33'(signed'(mb_q[18:1])); end
			3'd2: begin fa = 33'(signed'(pa_q[30:0])); fb = 33'(signed'(pb_q[30:0])); end
			3'd3: begin fa = 33'(signed'(pa_q[62:31])); fb = 33'(signed'(pb_q[62:31])); end
			3'd4: begin fa = 33'(signed'(ma_q[34:19])); fb = 33'(signed'(mb_q[34:19])); end
			3'd5: begin fa = 33'({1'b0, ma_q[48:35]}); fb = 33'({1'b0, mb_q[48:35]}); end
			3'd6: begin fa = 33'({1'b0, ma_q[63:49]}); fb = 33'({1'b0, mb_q[63:49]}); end
			default: ;
		endcase
		dlt = 34'(fb) - 34'(fa);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lerp_busy_q <= 1'b0;
			fld_q <= 3'd1;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= lerp_busy_q;
			if (cmd.lerp_go) begin
				lerp_busy_q <= 1'b1;
				fld_q <= 3'd1;
			end else if (lerp_busy_q) begin
				if (fld_q == 3'd6) lerp_busy_q <= 1'b0;
				fld_q <= fld_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= dlt * $signed({1'b0, frac});
		a_s1 <= fa;
		fld_s1 <= fld_q;
		if (v_s1) res[fld_s1] <= a_s1 + 33'(prod_s1 >>> FRAC_W);
	end

	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1 && fld_s1 == 3'd6;
	end
	assign lerp_done = v_s2;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.emit_status;
			out_stamp_ms <= '0;
			out_grounded <= 1'b0;
			out_altitude_ft <= '0;
			out_lat_e7 <= '0;
			out_lon_e7 <= '0;
			out_climb_ft_min <= '0;
			out_speed_eighth_kt <= '0;
			out_heading_64th_deg <= '0;
			if (cmd.emit_status == ST_SAMPLE) begin
				out_stamp_ms <= ta_q;
				out_grounded <= ma_q[0];
				out_altitude_ft <= ma_q[18:1];
				out_lat_e7 <= pa_q[30:0];
				out_lon_e7 <= pa_q[62:31];
				out_climb_ft_min <= ma_q[34:19];
				out_speed_eighth_kt <= ma_q[48:35];
				out_heading_64th_deg <= ma_q[63:49];
			end else if (cmd.emit_status == ST_INTERP) begin
				out_stamp_ms <= q_q;
				out_grounded <= ma_q[0];
				out_altitude_ft <= res[1][17:0];
				out_lat_e7 <= res[2][30:0];
				out_lon_e7 <= res[3][31:0];
				out_climb_ft_min <= res[4][15:0];
				out_speed_eighth_kt <= res[5][13:0];
				out_heading_64th_deg <= res[6][14:0];
			end
		end
	end
endmodule

@@ sv/tsl_ctrl.sv @@
// Controller state machine for the track sample lookup block.
// Depends on tsl_pkg and the assertion macro header.
`include "track_sample_lookup_interp_defines.svh"
module tsl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tsl_pkg::tsl_sts_t sts,
	output tsl_pkg::tsl_cmd_t cmd
);
	import tsl_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_APPEND;
			S_APPEND: begin
				unique case (sts.op)
					OP_QUERY: state_d = S_QFIRST;
					default:  state_d = S_DONE;
				endcase
			end
			S_QFIRST: state_d = S_QLAST;
			S_QLAST: state_d = S_QCHK;
			S_QCHK: state_d = sts.out_of_span ? S_DONE : S_RD;
			S_RD: state_d = S_RDWAIT;
			S_RDWAIT: state_d = S_EVAL;
			S_EVAL: begin
				if (sts.hit_interp) state_d = S_DIV;
				else if (sts.hit_sample || sts.walk_end) state_d = S_DONE;
				else state_d = S_RD;
			end
			S_DIV: if (sts.div_done) state_d = S_LERP;
			S_LERP: if (sts.lerp_done) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// registered flags of how the item ended
	logic is_interp_q, is_sample_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_interp_q <= 1'b0;
			is_sample_q <= 1'b0;
		end else begin
			if (state_q == S_APPEND) begin
				is_interp_q <= 1'b0;
				is_sample_q <= 1'b0;
			end
			if (state_q == S_EVAL) begin
				if (sts.hit_interp) begin
					is_interp_q <= 1'b1;
				end else if (sts.hit_sample || (sts.walk_end && sts.tol_hit)) begin
					is_sample_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.emit_status = ST_NOTFOUND;
		busy = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: cmd.cap_in = start;
			S_APPEND: begin
				// last stamp read issued here; address is count-1
				cmd.rd_last = 1'b1;
			end
			S_QFIRST: begin
				cmd.rd_first = 1'b1;
				cmd.ld_last = 1'b1;
			end
			S_QLAST: cmd.ld_first = 1'b1;
			S_QCHK: cmd.init_cur = !sts.out_of_span;
			S_RD: ;
			S_RDWAIT: ;
			S_EVAL: begin
				if (sts.hit_interp) cmd.div_start = 1'b1;
				if (sts.hit_interp || sts.hit_sample || sts.walk_end) cmd.commit = 1'b1;
				else cmd.step_cur = 1'b1;
			end
			S_DIV: cmd.lerp_go = sts.div_done;
			S_LERP: ;
			S_DONE: begin
				cmd.emit = 1'b1;
				unique case (sts.op)
					OP_APPEND: begin
						// last stamp is on read port A by now
						cmd.do_append = sts.append_ok;
						cmd.emit_status = sts.append_ok ? ST_APPENDED : ST_REJECTED;
					end
					OP_QUERY: begin
						if (is_interp_q) cmd.emit_status = ST_INTERP;
						else if (is_sample_q) cmd.emit_status = ST_SAMPLE;
						else cmd.emit_status = ST_NOTFOUND;
					end
					OP_CRESET: begin
						cmd.creset = 1'b1;
						cmd.emit_status = ST_CRESET;
					end
					default: cmd.emit_status = ST_NOTFOUND;
				endcase
			end
			default: ;
		endcase
	end

	`TSL_ASSERT_IMP(a_emit_in_done, clk, arst_n, cmd.emit, state_q == S_DONE)
	`TSL_ASSERT_NEXT(a_done_to_idle, clk, arst_n, state_q == S_DONE, state_q == S_IDLE)
	`TSL_ASSERT_IMP(a_step_not_commit, clk, arst_n, cmd.step_cur, !cmd.commit)
	`TSL_ASSERT_IMP(a_interp_status, clk, arst_n,
		cmd.emit && cmd.emit_status == ST_INTERP, is_interp_q && !is_sample_q)
endmodule
